FILE: hdl/mipds_pkg.sv
// ----------------------------------------------------------------------------
// mipds_pkg
// Shared widths, masks, register indexes and per-beat control types for the
// 2x2 box-filter mip downsampler.
// ----------------------------------------------------------------------------
package mipds_pkg;

  localparam int PIXEL_W           = 32;
  localparam int CFG_W             = 13;
  localparam int CFG_IDX_W         = 1;
  localparam int ROW_W             = 12;
  localparam int MAX_HEIGHT        = 4096;
  localparam int DEFAULT_MAX_WIDTH = 4096;

  localparam logic [PIXEL_W-1:0] QUARTER_MASK = 32'h3f3f3f3f;
  localparam logic [PIXEL_W-1:0] HALF_MASK    = 32'h7f7f7f7f;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'd1;

  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_HOLD      = 3'd1,
    OP_WRITE     = 3'd2,
    OP_EMIT_LINE = 3'd3,
    OP_EMIT      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SRC_QUARTER = 2'd0,
    SRC_HALF    = 2'd1,
    SRC_RAW     = 2'd2
  } src_t;

  typedef struct packed {
    op_t  op;
    src_t src;
    logic add_pair;
    logic row_end;
    logic image_end;
  } ctrl_t;

endpackage

FILE: hdl/mipds_seq.sv
// ----------------------------------------------------------------------------
// mipds_seq
// Holds the image size, tracks the source position, classifies each beat and
// registers it with its line buffer address for the datapath.
// ----------------------------------------------------------------------------
module mipds_seq #(
  parameter int MAX_WIDTH = mipds_pkg::DEFAULT_MAX_WIDTH,
  parameter int AW        = 11
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mipds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mipds_pkg::CFG_W-1:0]       cfg_data,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic [mipds_pkg::PIXEL_W-1:0]     pixel_in,
  output logic                              s1_valid,
  output logic [mipds_pkg::PIXEL_W-1:0]     s1_pixel,
  output mipds_pkg::ctrl_t                  s1_ctrl,
  output logic [AW-1:0]                     s1_addr,
  input  logic                              s1_take
);
  import mipds_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CW-1:0]    last_col;
  logic [CW-1:0]    last_x;
  logic [ROW_W-1:0] last_row;
  logic [ROW_W-1:0] last_y;
  logic [CW-1:0]    last_col_next;
  logic [CW-1:0]    last_x_next;
  logic [ROW_W-1:0] last_row_next;
  logic [ROW_W-1:0] last_y_next;

  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [CW-1:0]    x;
  logic [ROW_W-1:0] y;
  logic             accept;
  ctrl_t            ctrl;

  always_comb begin
    int unsigned wv;
    int unsigned hw;
    wv = 32'(cfg_data);
    if (wv == 0) begin
      wv = 1;
    end
    if (wv > MAX_WIDTH) begin
      wv = MAX_WIDTH;
    end
    hw = wv >> 1;
    if (hw == 0) begin
      hw = 1;
    end
    last_col_next = CW'(wv - 1);
    last_x_next   = CW'(hw - 1);
  end

  always_comb begin
    int unsigned hv;
    int unsigned hh;
    hv = 32'(cfg_data);
    if (hv == 0) begin
      hv = 1;
    end
    if (hv > MAX_HEIGHT) begin
      hv = MAX_HEIGHT;
    end
    hh = hv >> 1;
    if (hh == 0) begin
      hh = 1;
    end
    last_row_next = ROW_W'(hv - 1);
    last_y_next   = ROW_W'(hh - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= '0;
      last_x   <= '0;
      last_row <= '0;
      last_y   <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_SOURCE_WIDTH) begin
        last_col <= last_col_next;
        last_x   <= last_x_next;
      end
      if (cfg_index == REG_SOURCE_HEIGHT) begin
        last_row <= last_row_next;
        last_y   <= last_y_next;
      end
    end
  end

  assign sample_ready = !s1_valid || s1_take;
  assign accept       = sample_valid && sample_ready;
  assign x            = col >> 1;
  assign y            = row >> 1;

  always_comb begin
    ctrl           = '0;
    ctrl.op        = OP_NONE;
    ctrl.src       = SRC_QUARTER;
    ctrl.row_end   = (x == last_x);
    ctrl.image_end = (x == last_x) && (y == last_y);
    if (x <= last_x && y <= last_y) begin
      if (y != last_y) begin
        if (x != last_x) begin
          if (!col[0]) begin
            ctrl.op = OP_HOLD;
          end else begin
            ctrl.add_pair = 1'b1;
            ctrl.op       = row[0] ? OP_EMIT_LINE : OP_WRITE;
          end
        end else if (!col[0]) begin
          ctrl.src = SRC_HALF;
          ctrl.op  = row[0] ? OP_EMIT_LINE : OP_WRITE;
        end
      end else if (!row[0]) begin
        if (x != last_x) begin
          ctrl.src = SRC_HALF;
          if (!col[0]) begin
            ctrl.op = OP_HOLD;
          end else begin
            ctrl.add_pair = 1'b1;
            ctrl.op       = OP_EMIT;
          end
        end else if (!col[0]) begin
          ctrl.src = SRC_RAW;
          ctrl.op  = OP_EMIT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == last_col) begin
        col <= '0;
        row <= (row == last_row) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel_in;
      s1_ctrl  <= ctrl;
      s1_addr  <= x[AW-1:0];
    end
  end

endmodule

FILE: hdl/mipds_line.sv
// ----------------------------------------------------------------------------
// mipds_line
// Per-channel scaling, horizontal pair hold, even-row line buffer, final sum
// and the output register.
// ----------------------------------------------------------------------------
module mipds_line #(
  parameter int DEPTH = mipds_pkg::DEFAULT_MAX_WIDTH / 2,
  parameter int AW    = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s1_valid,
  input  logic [mipds_pkg::PIXEL_W-1:0] s1_pixel,
  input  mipds_pkg::ctrl_t              s1_ctrl,
  input  logic [AW-1:0]                 s1_addr,
  output logic                          s1_take,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [mipds_pkg::PIXEL_W-1:0] pixel_out,
  output logic                          row_end,
  output logic                          image_end
);
  import mipds_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rd_data;
  logic [PIXEL_W-1:0] pair_hold;
  logic [PIXEL_W-1:0] base;
  logic [PIXEL_W-1:0] val;
  logic               is_emit;
  logic               out_free;
  logic               s2_free;
  logic               s2_move;

  logic               s2_valid;
  logic [PIXEL_W-1:0] s2_val;
  logic               s2_use_line;
  logic               s2_row_end;
  logic               s2_image_end;

  always_comb begin
    case (s1_ctrl.src)
      SRC_QUARTER: base = (s1_pixel >> 2) & QUARTER_MASK;
      SRC_HALF:    base = (s1_pixel >> 1) & HALF_MASK;
      SRC_RAW:     base = s1_pixel;
      default:     base = s1_pixel;
    endcase
  end

  assign val      = base + (s1_ctrl.add_pair ? pair_hold : '0);
  assign is_emit  = (s1_ctrl.op == OP_EMIT_LINE) || (s1_ctrl.op == OP_EMIT);
  assign out_free = !result_valid || result_ready;
  assign s2_move  = s2_valid && out_free;
  assign s2_free  = !s2_valid || s2_move;
  assign s1_take  = s1_valid && (!is_emit || s2_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_hold <= '0;
    end else if (s1_take && s1_ctrl.op == OP_HOLD) begin
      pair_hold <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_ctrl.op == OP_WRITE) begin
      mem[s1_addr] <= val;
    end
    if (s1_take && is_emit) begin
      rd_data <= mem[s1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_take && is_emit) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && is_emit) begin
      s2_val       <= val;
      s2_use_line  <= (s1_ctrl.op == OP_EMIT_LINE);
      s2_row_end   <= s1_ctrl.row_end;
      s2_image_end <= s1_ctrl.image_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      pixel_out <= s2_val + (s2_use_line ? rd_data : '0);
      row_end   <= s2_row_end;
      image_end <= s2_image_end;
    end
  end

endmodule

FILE: hdl/mip_box_downsample_rgba_top.sv
// ----------------------------------------------------------------------------
// mip_box_downsample_rgba_top
// 2x2 box-filter downsampler producing the next mip level of an RGBA8888
// raster stream.
// ----------------------------------------------------------------------------
// The block takes one source pixel beat per clock and keeps that rate without
// gaps while result_ready stays high, whatever mix of even and odd rows
// arrives. A result beat passes the input register, the line buffer read and
// the output register; the single-port-write, single-port-read line buffer of
// MAX_WIDTH/2 words is touched once per beat, which is what sets the
// one-beat-per-cycle figure. Each channel is averaged with truncation.
// Writing either size register restarts the image at its first pixel; write
// sizes only while no beat is in flight. Sizes of zero read as one, and sizes
// above the limits are clipped.
// ----------------------------------------------------------------------------
module mip_box_downsample_rgba_top #(
  parameter int MAX_WIDTH = mipds_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mipds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mipds_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  logic [mipds_pkg::PIXEL_W-1:0]   pixel_in,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [mipds_pkg::PIXEL_W-1:0]   pixel_out,
  output logic                            row_end,
  output logic                            image_end
);
  import mipds_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_pixel;
  ctrl_t              s1_ctrl;
  logic [AW-1:0]      s1_addr;
  logic               s1_take;

  mipds_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .pixel_in     (pixel_in),
    .s1_valid     (s1_valid),
    .s1_pixel     (s1_pixel),
    .s1_ctrl      (s1_ctrl),
    .s1_addr      (s1_addr),
    .s1_take      (s1_take)
  );

  mipds_line #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1_pixel     (s1_pixel),
    .s1_ctrl      (s1_ctrl),
    .s1_addr      (s1_addr),
    .s1_take      (s1_take),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .row_end      (row_end),
    .image_end    (image_end)
  );

`ifndef NO_ASSERTIONS
  // The last pixel of the image is always the last pixel of its row.
  a_image_end_row: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (row_end || !image_end))
    else $error("image_end without row_end");

  // With the output register empty, the pipeline always has room for a beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> sample_ready)
    else $error("input stalled while output register empty");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");
`endif

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2x2 box-filter mip downsampler. A table of
// directed beats covers the reset sizes, zero sizes, the 2x2 and 4x4 levels
// and the interior, edge and corner cases. Random images of small sizes
// follow, then short runs at the widest and tallest clipped sizes. Every
// result beat is checked against its table value or an in-bench model of the
// filter, with random source gaps and random result stalls.
// ----------------------------------------------------------------------------
module testbench;
  import mipds_pkg::*;

  localparam int LINE_DEPTH    = DEFAULT_MAX_WIDTH / 2;
  localparam int STALL_PCT     = 26;
  localparam int RANDOM_BEATS  = 960;
  localparam int SETTLE_CYCLES = 8;
  localparam int STUCK_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               row_end;
    logic               image_end;
  } mip_beat_t;

  typedef struct {
    bit                   resize;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     size;
    logic [PIXEL_W-1:0]   pixel;
    bit                   typed;
    mip_beat_t            want;
  } probe_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 sample_valid;
  logic                 sample_ready;
  logic [PIXEL_W-1:0]   pixel_in;
  logic                 result_valid;
  logic                 result_ready;
  logic [PIXEL_W-1:0]   pixel_out;
  logic                 row_end;
  logic                 image_end;

  logic                 steady;
  int                   bad_beats;
  int                   stuck_cycles;

  logic [CFG_W-1:0]     width_reg;
  logic [CFG_W-1:0]     height_reg;
  logic [PIXEL_W-1:0]   line_sums [LINE_DEPTH];
  logic [PIXEL_W-1:0]   pair_sum;
  int                   src_col;
  int                   src_row;
  bit                   predicted;
  mip_beat_t            mips_due [$];
  probe_t               probes [$];

  mip_box_downsample_rgba_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .pixel_in     (pixel_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .row_end      (row_end),
    .image_end    (image_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [PIXEL_W-1:0] random_pixel();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return '0;
    if (roll < 6) return '1;
    if (roll < 8) return 32'h03030303;
    return $urandom;
  endfunction

  function automatic logic [CFG_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return '0;
    if (roll < 80) return CFG_W'($urandom_range(1, 9));
    return CFG_W'($urandom_range(10, 34));
  endfunction

  task automatic filter_pixel(input logic [PIXEL_W-1:0] px);
    int                 full_w;
    int                 full_h;
    int                 mip_w;
    int                 mip_h;
    int                 x;
    int                 y;
    logic               col_odd;
    logic               row_odd;
    logic               hit;
    logic [PIXEL_W-1:0] quarter_px;
    logic [PIXEL_W-1:0] half_px;
    logic [PIXEL_W-1:0] sum;
    mip_beat_t          beat;
    full_w = (width_reg == 0) ? 1 : int'(width_reg);
    if (full_w > DEFAULT_MAX_WIDTH) full_w = DEFAULT_MAX_WIDTH;
    full_h = (height_reg == 0) ? 1 : int'(height_reg);
    if (full_h > MAX_HEIGHT) full_h = MAX_HEIGHT;
    mip_w = (full_w >> 1 < 1) ? 1 : full_w >> 1;
    mip_h = (full_h >> 1 < 1) ? 1 : full_h >> 1;
    x = src_col >> 1;
    y = src_row >> 1;
    col_odd = src_col[0];
    row_odd = src_row[0];
    quarter_px = (px >> 2) & QUARTER_MASK;
    half_px = (px >> 1) & HALF_MASK;
    hit = 1'b0;
    sum = '0;
    if (x < mip_w && y < mip_h && x < LINE_DEPTH) begin
      if (y < mip_h - 1) begin
        if (x < mip_w - 1) begin
          if (!col_odd) begin
            pair_sum = quarter_px;
          end else if (!row_odd) begin
            line_sums[x] = pair_sum + quarter_px;
          end else begin
            sum = line_sums[x] + pair_sum + quarter_px;
            hit = 1'b1;
          end
        end else if (!col_odd) begin
          if (!row_odd) begin
            line_sums[x] = half_px;
          end else begin
            sum = line_sums[x] + half_px;
            hit = 1'b1;
          end
        end
      end else if (!row_odd) begin
        if (x < mip_w - 1) begin
          if (!col_odd) begin
            pair_sum = half_px;
          end else begin
            sum = pair_sum + half_px;
            hit = 1'b1;
          end
        end else if (!col_odd) begin
          sum = px;
          hit = 1'b1;
        end
      end
    end
    if (src_col + 1 >= full_w) begin
      src_col = 0;
      src_row = (src_row + 1 >= full_h) ? 0 : src_row + 1;
    end else begin
      src_col = src_col + 1;
    end
    predicted = hit;
    if (hit) begin
      beat = '{pixel: sum, row_end: (x == mip_w - 1),
               image_end: (x == mip_w - 1 && y == mip_h - 1)};
      mips_due.insert(mips_due.size(), beat);
    end
  endtask

  task automatic offer_pixel(input logic [PIXEL_W-1:0] px);
    if (!steady && $urandom_range(99) < STALL_PCT) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(99) < STALL_PCT);
    end
    sample_valid <= 1'b1;
    pixel_in <= px;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    filter_pixel(px);
  endtask

  // Leaves the block idle: no source beat offered and every result delivered.
  task automatic drain();
    sample_valid <= 1'b0;
    while (mips_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == REG_SOURCE_WIDTH) width_reg = value;
    else height_reg = value;
    src_col = 0;
    src_row = 0;
    pair_sum = '0;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic stream_image(input int count, input bit allow_pause);
    for (int k = 0; k < count; k++) begin
      if (allow_pause && (k == count / 2 || $urandom_range(199) == 0)) drain();
      offer_pixel(random_pixel());
    end
  endtask

  task automatic add_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    probe_t entry;
    entry = '{resize: 1'b1, reg_index: idx, size: value, pixel: '0,
              typed: 1'b0, want: '0};
    probes.insert(probes.size(), entry);
  endtask

  task automatic add_pixel(input logic [PIXEL_W-1:0] px);
    probe_t entry;
    entry = '{resize: 1'b0, reg_index: '0, size: '0, pixel: px,
              typed: 1'b0, want: '0};
    probes.insert(probes.size(), entry);
  endtask

  task automatic add_typed(input logic [PIXEL_W-1:0] px, input logic [PIXEL_W-1:0] mip,
                           input logic re, input logic ie);
    probe_t entry;
    entry.resize    = 1'b0;
    entry.reg_index = '0;
    entry.size      = '0;
    entry.pixel     = px;
    entry.typed     = 1'b1;
    entry.want      = '{pixel: mip, row_end: re, image_end: ie};
    probes.insert(probes.size(), entry);
  endtask

  always @(posedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin : check_results
    mip_beat_t got;
    mip_beat_t want;
    if (!rst && result_valid && result_ready) begin
      got = '{pixel: pixel_out, row_end: row_end, image_end: image_end};
      if (mips_due.size() == 0) begin
        bad_beats++;
        if (bad_beats <= REPORT_LIMIT)
          $display("Unexpected result beat: pixel_out=%h row_end=%b image_end=%b",
                   got.pixel, got.row_end, got.image_end);
      end else begin
        want = mips_due[0];
        mips_due.delete(0);
        if (got.pixel !== want.pixel || got.row_end !== want.row_end ||
            got.image_end !== want.image_end) begin
          bad_beats++;
          if (bad_beats <= REPORT_LIMIT)
            $display("Result mismatch: pixel_out=%h/%h row_end=%b/%b image_end=%b/%b",
                     got.pixel, want.pixel, got.row_end, want.row_end,
                     got.image_end, want.image_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles + 1 >= STUCK_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int random_count;
    int phase;
    int area;
    int count;
    int roll;
    logic [CFG_W-1:0] w_pick;
    logic [CFG_W-1:0] h_pick;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_valid = 1'b0;
    pixel_in = '0;
    steady = 1'b0;
    width_reg = CFG_W'(1);
    height_reg = CFG_W'(1);
    pair_sum = '0;
    src_col = 0;
    src_row = 0;
    predicted = 1'b0;
    foreach (line_sums[i]) line_sums[i] = '0;

    add_typed(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1);
    add_typed(32'h00000000, 32'h00000000, 1'b1, 1'b1);
    add_size(REG_SOURCE_WIDTH, CFG_W'(0));
    add_size(REG_SOURCE_HEIGHT, CFG_W'(0));
    add_typed(32'hA5A5A5A5, 32'hA5A5A5A5, 1'b1, 1'b1);
    add_size(REG_SOURCE_WIDTH, CFG_W'(2));
    add_size(REG_SOURCE_HEIGHT, CFG_W'(2));
    add_typed(32'h12345678, 32'h12345678, 1'b1, 1'b1);
    add_pixel(32'h80FF0001);
    add_pixel(32'h7F00FFFE);
    add_pixel(32'hC3C3C3C3);
    // A 4x4 source: unused last column and last row carry zeros.
    add_size(REG_SOURCE_WIDTH, CFG_W'(4));
    add_size(REG_SOURCE_HEIGHT, CFG_W'(4));
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (r == 1 && c == 1) add_typed('1, 32'hFCFCFCFC, 1'b0, 1'b0);
        else if (r == 1 && c == 2) add_typed('1, 32'hFEFEFEFE, 1'b1, 1'b0);
        else if (r == 2 && c == 1) add_typed('1, 32'hFEFEFEFE, 1'b0, 1'b0);
        else if (r == 2 && c == 2) add_typed('1, 32'hFFFFFFFF, 1'b1, 1'b1);
        else if (r == 3 || c == 3) add_pixel('0);
        else add_pixel('1);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probes[i]) begin
      if (probes[i].resize) begin
        write_size(probes[i].reg_index, probes[i].size);
      end else begin
        offer_pixel(probes[i].pixel);
        if (probes[i].typed) begin
          if (predicted) mips_due.delete(mips_due.size() - 1);
          mips_due.insert(mips_due.size(), probes[i].want);
        end
      end
    end

    random_count = 0;
    phase = 0;
    while (random_count < RANDOM_BEATS) begin
      w_pick = pick_size();
      h_pick = pick_size();
      roll = $urandom_range(99);
      if (roll >= 15) write_size(REG_SOURCE_HEIGHT, h_pick);
      if (roll < 15 || roll >= 30) write_size(REG_SOURCE_WIDTH, w_pick);
      steady <= (phase >= 2 && phase < 5);
      area = ((width_reg == 0) ? 1 : int'(width_reg)) *
             ((height_reg == 0) ? 1 : int'(height_reg));
      count = ($urandom_range(99) < 70) ? area * $urandom_range(1, 2)
                                        : $urandom_range(1, area);
      if (count > RANDOM_BEATS - random_count) count = RANDOM_BEATS - random_count;
      stream_image(count, phase == 3);
      random_count += count;
      phase++;
    end

    steady <= 1'b0;
    write_size(REG_SOURCE_WIDTH, CFG_W'(4096));
    write_size(REG_SOURCE_HEIGHT, CFG_W'(1));
    stream_image(32, 1'b0);
    write_size(REG_SOURCE_WIDTH, CFG_W'(8191));
    write_size(REG_SOURCE_HEIGHT, CFG_W'(8191));
    steady <= 1'b1;
    stream_image(64, 1'b0);
    steady <= 1'b0;
    write_size(REG_SOURCE_WIDTH, CFG_W'(1));
    stream_image(64, 1'b0);

    drain();
    if (bad_beats == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
